### design/offset_tukey_window_generator_defines.svh
// Assertion macros for the offset Tukey window generator.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef OFFSET_TUKEY_WINDOW_GENERATOR_DEFINES_SVH
`define OFFSET_TUKEY_WINDOW_GENERATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define OTW_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define OTW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define OTW_ASSERT_SAME(lbl, ante, cons)
`define OTW_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### design/otw_pkg.sv
// Shared types, constants and tables for the offset Tukey window generator.
// No dependencies.
package otw_pkg;

    localparam int MAX_LENGTH     = 4096;
    localparam int COEF_FRAC_BITS = 16;
    localparam int CORDIC_STEPS   = 24;
    localparam int DIV_STEPS      = 31;

    localparam logic [1:0] REG_WINDOW_LENGTH  = 2'd0;
    localparam logic [1:0] REG_TAPER_FRACTION = 2'd1;
    localparam logic [1:0] REG_WINDOW_CENTER  = 2'd2;

    localparam logic [30:0] Q30_HALF_PI    = 31'd1686629713;
    localparam logic [30:0] Q30_ONE        = 31'd1073741824;
    localparam logic [33:0] Q30_GAIN_INV   = 34'd652032874;
    localparam logic [16:0] COEF_ONE       = 17'd65536;

    typedef struct packed {
        logic [12:0] len;
        logic        short_len;
        logic        left;
        logic [13:0] off;
        logic [13:0] nm1;
        logic [29:0] den;
    } cfg_t;

    // Flags that ride along with an item through the arithmetic stages.
    typedef struct packed {
        logic oor;
        logic short_len;
        logic flat;
    } side_t;

    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] r;
        unique case (i)
            0: r = 32'h3243F6A8;
            1: r = 32'h1DAC6705;
            2: r = 32'h0FADBAFC;
            3: r = 32'h07F56EA6;
            4: r = 32'h03FEAB76;
            5: r = 32'h01FFD55B;
            6: r = 32'h00FFFAAA;
            7: r = 32'h007FFF55;
            8: r = 32'h003FFFEA;
            9: r = 32'h001FFFFD;
            10: r = 32'h000FFFFF;
            11: r = 32'h0007FFFF;
            12: r = 32'h0003FFFF;
            13: r = 32'h0001FFFF;
            14: r = 32'h0000FFFF;
            15: r = 32'h00007FFF;
            16: r = 32'h00003FFF;
            17: r = 32'h00001FFF;
            18: r = 32'h00000FFF;
            19: r = 32'h000007FF;
            20: r = 32'h000003FF;
            21: r = 32'h000001FF;
            22: r = 32'h000000FF;
            default: r = 32'h0000007F;
        endcase
        return r;
    endfunction

endpackage

### design/otw_if.sv
// Handshake interfaces for the sample, result and configuration channels.
// Depends on nothing.
interface otw_sample_if;
    logic        valid;
    logic        ready;
    logic [11:0] sample_index;
    modport source (output valid, output sample_index, input ready);
    modport sink (input valid, input sample_index, output ready);
endinterface

interface otw_result_if;
    logic        valid;
    logic        ready;
    logic [16:0] coefficient;
    logic        index_out_of_range;
    modport source (output valid, output coefficient, output index_out_of_range, input ready);
    modport sink (input valid, input coefficient, input index_out_of_range, output ready);
endinterface

interface otw_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [16:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### design/offset_tukey_window_generator.sv
// Top level of the offset Tukey window generator.
// Depends on otw_pkg, otw_if, otw_cfg, otw_div, otw_cordic and the defines header.
//
// Each accepted sample index yields one window coefficient (unsigned Q1.16)
// and an out-of-range flag, in order. The block takes one transfer per clock
// cycle unless the sink holds the result back. Each item passes the index
// stages, the 31-stage phase divider, the 24-stage CORDIC and the output
// registers. The whole pipeline advances together: when the sink holds the
// result back, sample.ready drops in the same cycle and nothing is lost. The
// user must write registers through the cfg channel only while no item is in
// flight (not enforced); the derived window geometry is then registered.
`include "offset_tukey_window_generator_defines.svh"
module offset_tukey_window_generator (
    input  logic        clk,
    input  logic        rst_n,
    otw_cfg_if.sink     cfg,
    otw_sample_if.sink  sample,
    otw_result_if.source result
);
    import otw_pkg::*;

    cfg_t geom;

    // The pipeline moves whenever the output register is empty or being drained.
    logic en;
    logic out_valid_reg;
    assign en = !out_valid_reg || result.ready;
    assign sample.ready = en;

    otw_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .geom  (geom)
    );

    // Stage 1 captures the index.
    logic        v1_reg;
    logic [11:0] idx_reg;

    // Stage 2 folds the index to its distance from the nearer end.
    logic        v2_reg;
    logic        oor2_reg, small2_reg;
    logic [13:0] k_reg;
    logic [13:0] p, pk;

    // Stage 3 multiplies by pi/2 and checks the flat part.
    logic        v3_reg;
    side_t       side3_reg;
    logic [44:0] prod_reg;

    // Stage 4 forms the rounded dividend.
    logic        v4_reg;
    side_t       side4_reg;
    logic [61:0] dvd_reg;

    logic        div_valid;
    logic [30:0] theta;
    side_t       div_side;
    logic        cor_valid;
    logic signed [33:0] sine;
    side_t       cor_side;

    logic        v5_reg;
    side_t       side5_reg;
    logic [61:0] sq_reg;
    logic [30:0] s_clamp;

    logic [16:0] coef_next, coef_reg;
    logic        oor_reg;
    logic [17:0] rounded;

    always_comb
    begin
        p  = geom.left ? ({2'b00, idx_reg} + geom.off) : {2'b00, idx_reg};
        pk = geom.nm1 - p;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= sample.valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= cor_valid;
            out_valid_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx_reg    <= sample.sample_index;
            oor2_reg   <= {1'b0, idx_reg} >= geom.len;
            small2_reg <= geom.short_len;
            k_reg      <= (p < pk) ? p : pk;

            side3_reg.oor       <= oor2_reg;
            side3_reg.short_len <= small2_reg;
            side3_reg.flat      <= {k_reg, 17'd0} > {1'b0, geom.den};
            prod_reg            <= 45'(k_reg * Q30_HALF_PI);

            side4_reg <= side3_reg;
            dvd_reg   <= {prod_reg, 17'd0} + {33'd0, geom.den[29:1]};

            side5_reg <= cor_side;
            sq_reg    <= 62'(s_clamp * s_clamp);

            coef_reg <= coef_next;
            oor_reg  <= side5_reg.oor;
        end
    end

    otw_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v4_reg),
        .dividend  (dvd_reg),
        .den       (geom.den),
        .in_side   (side4_reg),
        .out_valid (div_valid),
        .quotient  (theta),
        .out_side  (div_side)
    );

    otw_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .theta     (theta),
        .in_side   (div_side),
        .out_valid (cor_valid),
        .sine      (sine),
        .out_side  (cor_side)
    );

    // The sine is held to [0, 1.0] before it is squared.
    always_comb
    begin
        priority if (sine[33])
            s_clamp = '0;
        else if (sine > $signed({3'b000, Q30_ONE}))
            s_clamp = Q30_ONE;
        else
            s_clamp = sine[30:0];
    end

    // Round the Q60 square to the coefficient width, halves up, capped at 1.0.
    always_comb
    begin
        rounded = 18'((sq_reg + (62'd1 << (59 - COEF_FRAC_BITS))) >> (60 - COEF_FRAC_BITS));
        priority if (side5_reg.oor)
            coef_next = '0;
        else if (side5_reg.short_len || side5_reg.flat)
            coef_next = COEF_ONE;
        else if (rounded > {1'b0, COEF_ONE})
            coef_next = COEF_ONE;
        else
            coef_next = rounded[16:0];
    end

    assign result.valid              = out_valid_reg;
    assign result.coefficient        = coef_reg;
    assign result.index_out_of_range = oor_reg;

    `OTW_ASSERT_SAME(a_oor_zero, result.valid && result.index_out_of_range, result.coefficient == 17'd0)
    `OTW_ASSERT_SAME(a_coef_cap, result.valid, result.coefficient <= COEF_ONE)
    `OTW_ASSERT_SAME(a_stall_blocks, result.valid && !result.ready, !sample.ready)
endmodule

### design/otw_cfg.sv
// Configuration registers and the window geometry derived from them.
// Depends on otw_pkg and otw_if.
module otw_cfg (
    input  logic         clk,
    input  logic         rst_n,
    otw_cfg_if.sink      cfg,
    output otw_pkg::cfg_t geom
);
    import otw_pkg::*;

    logic [12:0] length_reg;
    logic [16:0] taper_reg;
    logic [15:0] center_reg;

    logic [12:0] len_reg, len_next;
    logic        small_reg, small_next;
    logic        left_reg, left_next;
    logic [16:0] a_reg, a_next;
    logic [13:0] n2_reg, n2_next;
    cfg_t        geom_reg, geom_next;

    logic [16:0] c16;
    logic [17:0] mm16;
    logic [17:0] mx;
    logic [13:0] n2a;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= 13'd64;
            taper_reg  <= 17'd32768;
            center_reg <= 16'd0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_WINDOW_LENGTH:  length_reg <= cfg.data[12:0];
                REG_TAPER_FRACTION: taper_reg  <= cfg.data;
                REG_WINDOW_CENTER:  center_reg <= cfg.data[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        len_next   = (length_reg > 13'(MAX_LENGTH)) ? 13'(MAX_LENGTH) : length_reg;
        small_next = len_next < 13'd3;
        a_next     = (taper_reg == 17'd0 || taper_reg > COEF_ONE) ? COEF_ONE : taper_reg;
        c16        = (center_reg == 16'd0) ? {1'b0, len_next, 3'b000} : {1'b0, center_reg};
        left_next  = c16 < {1'b0, len_next, 3'b000};
        mm16       = {1'b0, len_next, 4'b0000} - {1'b0, c16};
        mx         = (mm16[17] || {1'b0, c16} > mm16) ? {1'b0, c16} : mm16;
        n2a        = 14'((mx + 18'd4) >> 3);
        n2_next    = (n2a < {1'b0, len_next}) ? {1'b0, len_next} : n2a;
    end

    always_comb
    begin
        geom_next.len       = len_reg;
        geom_next.short_len = small_reg;
        geom_next.left      = left_reg;
        geom_next.off       = n2_reg - {1'b0, len_reg};
        geom_next.nm1       = n2_reg - 14'd1;
        geom_next.den       = 30'(a_reg * (n2_reg - 14'd1));
    end

    always_ff @(posedge clk)
    begin
        len_reg   <= len_next;
        small_reg <= small_next;
        left_reg  <= left_next;
        a_reg     <= a_next;
        n2_reg    <= n2_next;
        geom_reg  <= geom_next;
    end

    assign geom = geom_reg;
endmodule

### design/otw_div.sv
// Pipelined restoring divider, one quotient bit per stage, for the taper phase.
// Depends on otw_pkg.
module otw_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [61:0]        dividend,
    input  logic [29:0]        den,
    input  otw_pkg::side_t     in_side,
    output logic               out_valid,
    output logic [30:0]        quotient,
    output otw_pkg::side_t     out_side
);
    import otw_pkg::*;

    logic        valid_reg [DIV_STEPS];
    logic [30:0] rem_reg   [DIV_STEPS];
    logic [30:0] low_reg   [DIV_STEPS];
    logic [30:0] quo_reg   [DIV_STEPS];
    side_t       side_reg  [DIV_STEPS];

    for (genvar s = 0; s < DIV_STEPS; s++)
    begin : g_step
        logic        v_in;
        logic [30:0] rem_in, low_in, quo_in;
        side_t       side_in;
        logic [31:0] rem2;
        logic        ge;

        if (s == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = dividend[61:31];
            assign low_in  = dividend[30:0];
            assign quo_in  = '0;
            assign side_in = in_side;
        end
        else
        begin : g_rest
            assign v_in    = valid_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign low_in  = low_reg[s-1];
            assign quo_in  = quo_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        assign rem2 = {rem_in, low_in[30]};
        assign ge   = rem2 >= {2'b00, den};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= ge ? 31'(rem2 - {2'b00, den}) : rem2[30:0];
                low_reg[s]  <= {low_in[29:0], 1'b0};
                quo_reg[s]  <= {quo_in[29:0], ge};
                side_reg[s] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[DIV_STEPS-1];
    assign quotient  = quo_reg[DIV_STEPS-1];
    assign out_side  = side_reg[DIV_STEPS-1];
endmodule

### design/otw_cordic.sv
// Pipelined rotation-mode CORDIC giving the sine of an unsigned Q1.30 angle.
// Depends on otw_pkg.
module otw_cordic (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [30:0]        theta,
    input  otw_pkg::side_t     in_side,
    output logic               out_valid,
    output logic signed [33:0] sine,
    output otw_pkg::side_t     out_side
);
    import otw_pkg::*;

    logic               valid_reg [CORDIC_STEPS];
    logic signed [33:0] x_reg     [CORDIC_STEPS];
    logic signed [33:0] y_reg     [CORDIC_STEPS];
    logic signed [33:0] z_reg     [CORDIC_STEPS];
    side_t              side_reg  [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        logic               v_in;
        logic signed [33:0] x_in, y_in, z_in;
        side_t              side_in;
        logic signed [33:0] dx, dy, at;

        if (i == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign x_in    = Q30_GAIN_INV;
            assign y_in    = '0;
            assign z_in    = {3'b000, theta};
            assign side_in = in_side;
        end
        else
        begin : g_rest
            assign v_in    = valid_reg[i-1];
            assign x_in    = x_reg[i-1];
            assign y_in    = y_reg[i-1];
            assign z_in    = z_reg[i-1];
            assign side_in = side_reg[i-1];
        end

        assign dx = y_in >>> i;
        assign dy = x_in >>> i;
        assign at = {2'b00, atan_q30(i)};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_in[33])
                begin
                    x_reg[i] <= x_in - dx;
                    y_reg[i] <= y_in + dy;
                    z_reg[i] <= z_in - at;
                end
                else
                begin
                    x_reg[i] <= x_in + dx;
                    y_reg[i] <= y_in - dy;
                    z_reg[i] <= z_in + at;
                end
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[CORDIC_STEPS-1];
    assign sine      = y_reg[CORDIC_STEPS-1];
    assign out_side  = side_reg[CORDIC_STEPS-1];
endmodule
